// ===== hw/rtl/tqc_pkg.sv =====
// shared types and constants of the textured quad clipper
package tqc_pkg;

    // field widths
    localparam int CW = 24;
    localparam int TW = 16;
    // internal position width, wide enough for clip edges and clipped sizes
    localparam int WW = ((CW > 26) ? CW : 26) + 3;
    // texcoord difference width and product width
    localparam int DW = TW + 1;
    localparam int PW = DW + WW;

    // configuration register indexes
    localparam logic [2:0] REG_CLIP_X = 3'd0;
    localparam logic [2:0] REG_CLIP_Y = 3'd1;
    localparam logic [2:0] REG_CLIP_W = 3'd2;
    localparam logic [2:0] REG_CLIP_H = 3'd3;
    localparam logic [2:0] REG_COLOR  = 3'd4;

    // corner codes
    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_BL = 2'd1;
    localparam logic [1:0] CORNER_BR = 2'd2;
    localparam logic [1:0] CORNER_TR = 2'd3;

    typedef struct packed {
        logic signed [CW-1:0] pos_x;
        logic signed [CW-1:0] pos_y;
        logic signed [CW-1:0] size_w;
        logic signed [CW-1:0] size_h;
        logic signed [TW-1:0] tex_s_start;
        logic signed [TW-1:0] tex_t_start;
        logic signed [TW-1:0] tex_s_end;
        logic signed [TW-1:0] tex_t_end;
        logic        [15:0]   material_id;
    } in_item_t;

    typedef struct packed {
        logic signed [CW-1:0] vert_x;
        logic signed [CW-1:0] vert_y;
        logic signed [TW-1:0] vert_s;
        logic signed [TW-1:0] vert_t;
        logic        [31:0]   vert_color;
        logic        [15:0]   vert_material;
        logic        [1:0]    corner;
        logic                 last_vertex;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] clip_x;
        logic signed [15:0] clip_y;
        logic        [15:0] clip_w;
        logic        [15:0] clip_h;
    } clip_cfg_t;

    // finished quad passed from front to back
    typedef struct packed {
        logic signed [CW-1:0] x0;
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y0;
        logic signed [CW-1:0] y1;
        logic signed [TW-1:0] s1;
        logic signed [TW-1:0] t1;
        logic signed [TW-1:0] s2;
        logic signed [TW-1:0] t2;
        logic        [15:0]   mat;
    } quad_t;

endpackage

// ===== hw/rtl/textured_quad_clipper.sv =====
// Textured quad clipper. Each rectangle transaction yields four vertex transactions
// (top-left, bottom-left, bottom-right, top-right) or none when it is clipped away.
// The vertex port emits one vertex per cycle while out_stall is low. With clipping
// disabled the front end passes a rectangle straight on; otherwise it checks
// the four clip edges in turn, and each edge that cuts into a rectangle of positive
// size runs the shared one-bit-per-cycle texcoord divider.
// A two-entry quad queue lets the front clip the next rectangle while the back
// still emits vertices. Registers: 0 clip_x, 1 clip_y, 2 clip_w, 3 clip_h,
// 4 vertex_color; write them only while the block is idle.
module textured_quad_clipper (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  tqc_pkg::in_item_t     in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output tqc_pkg::out_item_t    out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data
);

    tqc_pkg::clip_cfg_t  clip_reg;
    logic [31:0]         color_reg;
    logic                q_full, q_push, q_pop, q_valid;
    tqc_pkg::quad_t      q_in, q_head;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_reg  <= '0;
            color_reg <= 32'hFFFF_FFFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tqc_pkg::REG_CLIP_X: clip_reg.clip_x <= cfg_data[15:0];
                tqc_pkg::REG_CLIP_Y: clip_reg.clip_y <= cfg_data[15:0];
                tqc_pkg::REG_CLIP_W: clip_reg.clip_w <= cfg_data[15:0];
                tqc_pkg::REG_CLIP_H: clip_reg.clip_h <= cfg_data[15:0];
                tqc_pkg::REG_COLOR:  color_reg       <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    tqc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg      (clip_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    tqc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .head_data (q_head)
    );

    tqc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_head),
        .q_pop     (q_pop),
        .color     (color_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== hw/rtl/tqc_front.sv =====
// front end: accepts rectangles and clips them edge by edge with a serial divider
module tqc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tqc_pkg::in_item_t   in_data,
    input  tqc_pkg::clip_cfg_t  cfg,
    input  logic                q_full,
    output logic                q_push,
    output tqc_pkg::quad_t      q_data
);

    localparam int WW = tqc_pkg::WW;
    localparam int TW = tqc_pkg::TW;
    localparam int CW = tqc_pkg::CW;
    localparam int DW = tqc_pkg::DW;
    localparam int PW = tqc_pkg::PW;
    localparam int RW = PW + 2;
    localparam int NW = $clog2(PW + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CALC   = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_ABS    = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_APPLY  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    localparam logic [1:0] E_LEFT   = 2'd0;
    localparam logic [1:0] E_TOP    = 2'd1;
    localparam logic [1:0] E_RIGHT  = 2'd2;
    localparam logic [1:0] E_BOTTOM = 2'd3;

    localparam logic signed [RW-1:0] TEX_HI = RW'((64'sd1 <<< (TW - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] TEX_LO = -TEX_HI - RW'(1);
    localparam logic signed [WW:0]   POS_HI = (WW + 1)'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [WW:0]   POS_LO = -POS_HI - (WW + 1)'(1);

    // saturate a position to the coordinate width
    function automatic logic signed [CW-1:0] sat_pos(input logic signed [WW:0] v);
        logic signed [CW-1:0] r;
        if (v > POS_HI)
            r = POS_HI[CW-1:0];
        else if (v < POS_LO)
            r = POS_LO[CW-1:0];
        else
            r = v[CW-1:0];
        return r;
    endfunction

    logic [2:0]              state_reg, state_next;
    logic [1:0]              edge_reg;
    logic                    skip_reg;
    logic signed [WW-1:0]    x_reg, y_reg, w_reg, h_reg;
    logic signed [TW-1:0]    s1_reg, t1_reg, s2_reg, t2_reg;
    logic [15:0]             mat_reg;
    logic signed [WW-1:0]    c_reg;
    logic signed [DW-1:0]    diff_reg;
    logic signed [PW-1:0]    prod_reg;
    logic                    neg_reg;
    logic [PW-1:0]           num_reg;
    logic [WW-1:0]           rem_reg;
    logic [NW-1:0]           cnt_reg;

    logic signed [WW-1:0]    cl, ct, cr, cb;
    logic signed [17:0]      right_px, bottom_px;
    logic                    clip_en;
    logic signed [WW-1:0]    c_cur, size_cur;
    logic signed [DW-1:0]    diff_cur;
    logic signed [TW-1:0]    base_cur;
    logic                    accept, finish_done, quad_ok;
    logic [WW:0]             trial;
    logic                    trial_ge;
    logic signed [PW:0]      q_signed;
    logic signed [RW-1:0]    tex_sum;
    logic signed [TW-1:0]    tex_new;

    // clip edges in Q16.8 (left, top) and Q18.8 (right, bottom)
    assign right_px  = 18'($signed(cfg.clip_x)) + $signed({2'b00, cfg.clip_w});
    assign bottom_px = 18'($signed(cfg.clip_y)) + $signed({2'b00, cfg.clip_h});
    assign cl = WW'($signed({cfg.clip_x, 8'd0}));
    assign ct = WW'($signed({cfg.clip_y, 8'd0}));
    assign cr = WW'($signed({right_px, 8'd0}));
    assign cb = WW'($signed({bottom_px, 8'd0}));
    assign clip_en = (cfg.clip_w != 16'd0) && (cfg.clip_h != 16'd0);

    // per-edge cut amount, divisor, texcoord difference and base
    always_comb
    begin
        size_cur = edge_reg[0] ? h_reg : w_reg;
        case (edge_reg)
            E_LEFT:
            begin
                c_cur    = cl - x_reg;
                diff_cur = DW'(s2_reg) - DW'(s1_reg);
                base_cur = s1_reg;
            end
            E_TOP:
            begin
                c_cur    = ct - y_reg;
                diff_cur = DW'(t2_reg) - DW'(t1_reg);
                base_cur = t1_reg;
            end
            E_RIGHT:
            begin
                c_cur    = x_reg + w_reg - cr;
                diff_cur = DW'(s2_reg) - DW'(s1_reg);
                base_cur = s2_reg;
            end
            default:
            begin
                c_cur    = y_reg + h_reg - cb;
                diff_cur = DW'(t2_reg) - DW'(t1_reg);
                base_cur = t2_reg;
            end
        endcase
    end

    // restoring divider step
    assign trial    = {rem_reg, num_reg[PW-1]};
    assign trial_ge = trial >= (WW + 1)'(size_cur);

    // moved texcoord, saturated
    always_comb
    begin
        q_signed = neg_reg ? -$signed({1'b0, num_reg}) : $signed({1'b0, num_reg});
        if (edge_reg[1])
            tex_sum = RW'(base_cur) - RW'(q_signed);
        else
            tex_sum = RW'(base_cur) + RW'(q_signed);
        if (tex_sum > TEX_HI)
            tex_new = TEX_HI[TW-1:0];
        else if (tex_sum < TEX_LO)
            tex_new = TEX_LO[TW-1:0];
        else
            tex_new = tex_sum[TW-1:0];
    end

    // handoff to the queue
    assign quad_ok     = (w_reg > WW'(0)) && (h_reg > WW'(0));
    assign finish_done = (state_reg == S_FINISH) && (!quad_ok || !q_full);
    assign q_push      = (state_reg == S_FINISH) && quad_ok && !q_full;
    assign in_stall    = !((state_reg == S_IDLE) || finish_done);
    assign accept      = in_valid && !in_stall;

    always_comb
    begin
        q_data.x0  = sat_pos((WW + 1)'(x_reg));
        q_data.x1  = sat_pos((WW + 1)'(x_reg) + (WW + 1)'(w_reg));
        q_data.y0  = sat_pos((WW + 1)'(y_reg));
        q_data.y1  = sat_pos((WW + 1)'(y_reg) + (WW + 1)'(h_reg));
        q_data.s1  = s1_reg;
        q_data.t1  = t1_reg;
        q_data.s2  = s2_reg;
        q_data.t2  = t2_reg;
        q_data.mat = mat_reg;
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept)
                    state_next = clip_en ? S_CALC : S_FINISH;
            S_CALC:
                if (c_cur > WW'(0))
                    state_next = (size_cur > WW'(0)) ? S_MUL : S_APPLY;
                else if (edge_reg == E_BOTTOM)
                    state_next = S_FINISH;
            S_MUL:
                state_next = S_ABS;
            S_ABS:
                state_next = S_DIV;
            S_DIV:
                if (cnt_reg == NW'(1))
                    state_next = S_APPLY;
            S_APPLY:
                state_next = (edge_reg == E_BOTTOM) ? S_FINISH : S_CALC;
            S_FINISH:
                if (accept)
                    state_next = clip_en ? S_CALC : S_FINISH;
                else if (finish_done)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= WW'(in_data.pos_x);
            y_reg    <= WW'(in_data.pos_y);
            w_reg    <= WW'(in_data.size_w);
            h_reg    <= WW'(in_data.size_h);
            s1_reg   <= in_data.tex_s_start;
            t1_reg   <= in_data.tex_t_start;
            s2_reg   <= in_data.tex_s_end;
            t2_reg   <= in_data.tex_t_end;
            mat_reg  <= in_data.material_id;
            edge_reg <= E_LEFT;
        end
        else
        begin
            case (state_reg)
                S_CALC:
                begin
                    c_reg    <= c_cur;
                    diff_reg <= diff_cur;
                    skip_reg <= !(size_cur > WW'(0));
                    if (!(c_cur > WW'(0)) && (edge_reg != E_BOTTOM))
                        edge_reg <= edge_reg + 2'd1;
                end
                S_MUL:
                    prod_reg <= PW'(diff_reg) * PW'(c_reg);
                S_ABS:
                begin
                    neg_reg <= prod_reg[PW-1];
                    num_reg <= prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);
                    rem_reg <= '0;
                    cnt_reg <= NW'(PW);
                end
                S_DIV:
                begin
                    rem_reg <= trial_ge ? WW'(trial - (WW + 1)'(size_cur)) : trial[WW-1:0];
                    num_reg <= {num_reg[PW-2:0], trial_ge};
                    cnt_reg <= cnt_reg - NW'(1);
                end
                S_APPLY:
                begin
                    case (edge_reg)
                        E_LEFT:
                        begin
                            if (!skip_reg)
                                s1_reg <= tex_new;
                            w_reg <= w_reg - c_reg;
                            x_reg <= cl;
                        end
                        E_TOP:
                        begin
                            if (!skip_reg)
                                t1_reg <= tex_new;
                            h_reg <= h_reg - c_reg;
                            y_reg <= ct;
                        end
                        E_RIGHT:
                        begin
                            if (!skip_reg)
                                s2_reg <= tex_new;
                            w_reg <= w_reg - c_reg;
                        end
                        default:
                        begin
                            if (!skip_reg)
                                t2_reg <= tex_new;
                            h_reg <= h_reg - c_reg;
                        end
                    endcase
                    if (edge_reg != E_BOTTOM)
                        edge_reg <= edge_reg + 2'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // a push never meets a full queue
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("push into full queue");
    // the divider only runs with a positive divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (size_cur > WW'(0)))
        else $error("divide by non-positive size");
    // an item is taken only when the sequencer is free
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ((state_reg == S_IDLE) || (state_reg == S_FINISH)))
        else $error("item accepted while busy");
`endif

endmodule

// ===== hw/rtl/tqc_queue.sv =====
// two-entry queue of clipped quads between front and back
module tqc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tqc_pkg::quad_t  push_data,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output tqc_pkg::quad_t  head_data
);

    tqc_pkg::quad_t mem_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     count_reg;

    assign full      = count_reg == 2'd2;
    assign q_valid   = count_reg != 2'd0;
    assign head_data = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== hw/rtl/tqc_back.sv =====
// back end: expands each quad into four vertex transactions
module tqc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  tqc_pkg::quad_t        q_data,
    output logic                  q_pop,
    input  logic [31:0]           color,
    output logic                  out_valid,
    input  logic                  out_stall,
    output tqc_pkg::out_item_t    out_data
);

    logic                  out_valid_reg;
    tqc_pkg::out_item_t    out_data_reg, out_data_next;
    logic [1:0]            corner_reg;
    logic                  load;

    assign load      = q_valid && (!out_valid_reg || !out_stall);
    assign q_pop     = load && (corner_reg == tqc_pkg::CORNER_TR);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // vertex for the current corner
    always_comb
    begin
        out_data_next.vert_color    = color;
        out_data_next.vert_material = q_data.mat;
        out_data_next.corner        = corner_reg;
        out_data_next.last_vertex   = corner_reg == tqc_pkg::CORNER_TR;
        case (corner_reg)
            tqc_pkg::CORNER_TL:
            begin
                out_data_next.vert_x = q_data.x0;
                out_data_next.vert_y = q_data.y0;
                out_data_next.vert_s = q_data.s1;
                out_data_next.vert_t = q_data.t1;
            end
            tqc_pkg::CORNER_BL:
            begin
                out_data_next.vert_x = q_data.x0;
                out_data_next.vert_y = q_data.y1;
                out_data_next.vert_s = q_data.s1;
                out_data_next.vert_t = q_data.t2;
            end
            tqc_pkg::CORNER_BR:
            begin
                out_data_next.vert_x = q_data.x1;
                out_data_next.vert_y = q_data.y1;
                out_data_next.vert_s = q_data.s2;
                out_data_next.vert_t = q_data.t2;
            end
            default:
            begin
                out_data_next.vert_x = q_data.x1;
                out_data_next.vert_y = q_data.y0;
                out_data_next.vert_s = q_data.s2;
                out_data_next.vert_t = q_data.t1;
            end
        endcase
    end

    // output register and corner counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            corner_reg    <= tqc_pkg::CORNER_TL;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                corner_reg    <= corner_reg + 2'd1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    // a quad stays at the queue head until all four corners are out
    assert property (@(posedge clk) disable iff (!rst_n)
        (corner_reg != tqc_pkg::CORNER_TL) |-> q_valid)
        else $error("quad lost mid expansion");
    // after the last vertex is loaded the counter wraps to the first corner
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.last_vertex && $past(load)) |->
        (corner_reg == tqc_pkg::CORNER_TL))
        else $error("corner counter out of step");
    // loaded vertices carry the corner that was counted
    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (out_data_reg.corner == $past(corner_reg)))
        else $error("corner mismatch");
`endif

endmodule

// ===== tb/sv/textured_quad_clipper_tb.sv =====
// testbench for the textured quad clipper: scoreboard class, directed and random stimulus
`timescale 1ns / 1ps

module textured_quad_clipper_tb;

    localparam int CLK_HALF = 10;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam logic [2:0] REG_BAD = 3'd7;
    localparam int CW = tqc_pkg::CW;
    localparam int TW = tqc_pkg::TW;

    // scoreboard: clip and color registers plus the queue of expected vertices
    class vertex_scoreboard;
        logic signed [15:0] clip_x;
        logic signed [15:0] clip_y;
        logic [15:0] clip_w;
        logic [15:0] clip_h;
        logic [31:0] color;
        tqc_pkg::out_item_t pending[$];
        int errors;

        function new();
            clip_x = 0; clip_y = 0; clip_w = 0; clip_h = 0;
            color = 32'hFFFF_FFFF;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                tqc_pkg::REG_CLIP_X: clip_x = val[15:0];
                tqc_pkg::REG_CLIP_Y: clip_y = val[15:0];
                tqc_pkg::REG_CLIP_W: clip_w = val[15:0];
                tqc_pkg::REG_CLIP_H: clip_h = val[15:0];
                tqc_pkg::REG_COLOR:  color = val;
                default: ;
            endcase
        endfunction

        function longint clamp(longint v, int bits);
            longint hi;
            hi = (longint'(1) <<< (bits - 1)) - 1;
            if (v > hi) return hi;
            if (v < -hi - 1) return -hi - 1;
            return v;
        endfunction

        // texcoord shifted by diff * cut / size, truncating toward zero
        function longint shift_tex(longint base, longint diff, longint cut, longint size,
                                   bit add);
            longint q;
            if (size <= 0) return base;
            q = (diff * cut) / size;
            return clamp(add ? base + q : base - q, TW);
        endfunction

        // clip one rectangle and queue its four vertices unless it is clipped away
        function void note_rect(tqc_pkg::in_item_t r);
            longint x, y, w, h, s1, t1, s2, t2, cl, ct, cr, cb, c;
            longint vx[4], vy[4], vs[4], vt[4];
            tqc_pkg::out_item_t v;
            x = longint'(r.pos_x); y = longint'(r.pos_y);
            w = longint'(r.size_w); h = longint'(r.size_h);
            s1 = longint'(r.tex_s_start); t1 = longint'(r.tex_t_start);
            s2 = longint'(r.tex_s_end); t2 = longint'(r.tex_t_end);
            if (clip_w != 0 && clip_h != 0)
            begin
                cl = longint'(clip_x) * 256;
                ct = longint'(clip_y) * 256;
                cr = (longint'(clip_x) + longint'(clip_w)) * 256;
                cb = (longint'(clip_y) + longint'(clip_h)) * 256;
                c = cl - x;
                if (c > 0)
                begin
                    s1 = shift_tex(s1, s2 - s1, c, w, 1);
                    w -= c;
                    x = cl;
                end
                c = ct - y;
                if (c > 0)
                begin
                    t1 = shift_tex(t1, t2 - t1, c, h, 1);
                    h -= c;
                    y = ct;
                end
                c = x + w - cr;
                if (c > 0)
                begin
                    s2 = shift_tex(s2, s2 - s1, c, w, 0);
                    w -= c;
                end
                c = y + h - cb;
                if (c > 0)
                begin
                    t2 = shift_tex(t2, t2 - t1, c, h, 0);
                    h -= c;
                end
            end
            if (w <= 0 || h <= 0) return;
            vx[0] = x;     vy[0] = y;     vs[0] = s1; vt[0] = t1;
            vx[1] = x;     vy[1] = y + h; vs[1] = s1; vt[1] = t2;
            vx[2] = x + w; vy[2] = y + h; vs[2] = s2; vt[2] = t2;
            vx[3] = x + w; vy[3] = y;     vs[3] = s2; vt[3] = t1;
            for (int k = 0; k < 4; k++)
            begin
                v.vert_x = CW'(clamp(vx[k], CW));
                v.vert_y = CW'(clamp(vy[k], CW));
                v.vert_s = TW'(clamp(vs[k], TW));
                v.vert_t = TW'(clamp(vt[k], TW));
                v.vert_color = color;
                v.vert_material = r.material_id;
                v.corner = k[1:0];
                v.last_vertex = (k[1:0] == tqc_pkg::CORNER_TR);
                pending.push_back(v);
            end
        endfunction

        task check_vertex(tqc_pkg::out_item_t got);
            tqc_pkg::out_item_t e;
            if (pending.size() == 0)
            begin
                report_bad("vertex with none expected", 0, 0);
                return;
            end
            e = pending.pop_front();
            if (got.vert_x !== e.vert_x)
                report_bad("vert_x", longint'(got.vert_x), longint'(e.vert_x));
            if (got.vert_y !== e.vert_y)
                report_bad("vert_y", longint'(got.vert_y), longint'(e.vert_y));
            if (got.vert_s !== e.vert_s)
                report_bad("vert_s", longint'(got.vert_s), longint'(e.vert_s));
            if (got.vert_t !== e.vert_t)
                report_bad("vert_t", longint'(got.vert_t), longint'(e.vert_t));
            if (got.vert_color !== e.vert_color)
                report_bad("vert_color", longint'(got.vert_color), longint'(e.vert_color));
            if (got.vert_material !== e.vert_material)
                report_bad("vert_material", longint'(got.vert_material),
                           longint'(e.vert_material));
            if (got.corner !== e.corner)
                report_bad("corner", longint'(got.corner), longint'(e.corner));
            if (got.last_vertex !== e.last_vertex)
                report_bad("last_vertex", longint'(got.last_vertex),
                           longint'(e.last_vertex));
        endtask

        task report_bad(string what, longint got, longint want);
            errors++;
            $display("mismatch %s: got %0h expected %0h", what, got, want);
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    tqc_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 0;
    tqc_pkg::out_item_t out_data;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    vertex_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    longint cycles = 0;

    textured_quad_clipper dut (.*);

    always #CLK_HALF clk = ~clk;

    // timeout watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** textured_quad_clipper: FAILED **");
            $finish;
        end
    end

    // vertex side: random stall and checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_vertex(out_data);
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // one register write; cfg_valid is dropped again before the task returns
    task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    // valid stays high after the transaction so the next one can follow at once
    task automatic send_rect(tqc_pkg::in_item_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        in_data <= r;
        do @(posedge clk); while (in_stall);
        sb.note_rect(r);
    endtask

    // wait until every vertex is back, then let the front finish dead work
    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_clip(int cx, int cy, int cw, int ch);
        write_cfg(tqc_pkg::REG_CLIP_X, cx);
        write_cfg(tqc_pkg::REG_CLIP_Y, cy);
        write_cfg(tqc_pkg::REG_CLIP_W, cw);
        write_cfg(tqc_pkg::REG_CLIP_H, ch);
    endtask

    function automatic tqc_pkg::in_item_t make_rect(logic [23:0] x, logic [23:0] y,
                                                    logic [23:0] w, logic [23:0] h);
        tqc_pkg::in_item_t r;
        r.pos_x = x; r.pos_y = y; r.size_w = w; r.size_h = h;
        r.tex_s_start = 16'($urandom); r.tex_t_start = 16'($urandom);
        r.tex_s_end = 16'($urandom); r.tex_t_end = 16'($urandom);
        r.material_id = 16'($urandom);
        return r;
    endfunction

    // mostly rectangles near the clip window, some fully random
    function automatic tqc_pkg::in_item_t rand_rect();
        int base_x, base_y;
        if ($urandom_range(9) == 0)
            return make_rect(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
        base_x = int'(sb.clip_x) * 256;
        base_y = int'(sb.clip_y) * 256;
        return make_rect(24'(base_x + int'($urandom_range(40000)) - 20000),
                         24'(base_y + int'($urandom_range(40000)) - 20000),
                         24'(int'($urandom_range(40000)) - 2000),
                         24'(int'($urandom_range(40000)) - 2000));
    endfunction

    initial
    begin
        tqc_pkg::in_item_t r;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // clipping disabled: extremes pass through, saturation of far corners
        send_rect(make_rect(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
        send_rect(make_rect(24'h800000, 24'h800000, 24'h000001, 24'h000001));
        send_rect(make_rect(24'h800000, 24'h000000, 24'h7FFFFF, 24'h7FFFFF));
        send_rect(make_rect(24'h0, 24'h0, 24'h0, 24'h100));
        send_rect(make_rect(24'h0, 24'h0, 24'h800000, 24'h100));
        r = make_rect(24'h100, 24'h100, 24'h1000, 24'h1000);
        r.tex_s_start = 16'h8000; r.tex_s_end = 16'h7FFF;
        r.tex_t_start = 16'h7FFF; r.tex_t_end = 16'h8000;
        r.material_id = 16'hFFFF;
        send_rect(r);
        drain();

        // clipping enabled: cuts on each edge, full reject, bad divisor, bad index
        write_cfg(tqc_pkg::REG_COLOR, 32'h0000_0000);
        write_cfg(REG_BAD, 32'hDEAD_BEEF);
        set_clip(10, 20, 100, 50);
        send_rect(make_rect(24'd0, 24'd5120, 24'd12800, 24'd5120));
        send_rect(make_rect(24'd3840, 24'd0, 24'd5120, 24'd12800));
        send_rect(make_rect(24'd0, 24'd0, 24'd40000, 24'd40000));
        send_rect(make_rect(24'd5000, 24'd6000, 24'd2000, 24'd2000));
        send_rect(make_rect(24'd0, 24'd0, 24'd100, 24'd100));
        send_rect(make_rect(24'd0, 24'd0, 24'hFFFF00, 24'd9000));
        send_rect(make_rect(24'd4000, 24'd6000, 24'd1000, 24'hFFFF00));
        r = make_rect(24'd1000, 24'd1000, 24'd40000, 24'd40000);
        r.tex_s_start = 16'h8000; r.tex_s_end = 16'h7FFF;
        r.tex_t_start = 16'h8000; r.tex_t_end = 16'h7FFF;
        send_rect(r);
        drain();

        // extreme clip window
        write_cfg(tqc_pkg::REG_COLOR, 32'hFFFF_FFFF);
        set_clip(-32768, -32768, 65535, 65535);
        send_rect(make_rect(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF));
        send_rect(make_rect(24'h7FFF00, 24'h7FFF00, 24'h7FFFFF, 24'h7FFFFF));
        drain();
        set_clip(32767, 32767, 1, 65535);
        send_rect(make_rect(24'h7FFE00, 24'h7FFE00, 24'h7FFFFF, 24'h7FFFFF));
        drain();

        // random phases across idle patterns and clip settings
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 66; recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 66;
                end
                default:
                begin
                    send_idle_pct = 38; recv_stall_pct = 38;
                end
            endcase
            write_cfg(tqc_pkg::REG_COLOR, $urandom);
            if (phase == 7)
                set_clip(0, 0, 0, int'($urandom_range(65535)));
            else
                set_clip(int'($urandom_range(4000)) - 2000,
                         int'($urandom_range(4000)) - 2000,
                         int'($urandom_range(1, 300)), int'($urandom_range(1, 300)));
            for (int i = 0; i < 20; i++)
            begin
                send_rect(rand_rect());
                // hold off until the block has emptied
                if (i == 10)
                begin
                    in_valid <= 0;
                    while (sb.pending.size() != 0) @(posedge clk);
                end
            end
            drain();
        end

        if (sb.errors == 0)
            $display("** textured_quad_clipper: PASSED **");
        else
            $display("** textured_quad_clipper: FAILED **");
        $finish;
    end
endmodule

// ===== textured_quad_clipper.f =====
hw/rtl/tqc_pkg.sv
hw/rtl/tqc_front.sv
hw/rtl/tqc_queue.sv
hw/rtl/tqc_back.sv
hw/rtl/textured_quad_clipper.sv
tb/sv/textured_quad_clipper_tb.sv
